// ===== rtl/core/srfp_pkg.sv =====
// ----------------------------------------------------------------------------
// srfp_pkg
// Shared constants, types and helper functions for the scan raster frame
// PSNR block.
// ----------------------------------------------------------------------------
`default_nettype none

package srfp_pkg;

    // bitmap geometry
    localparam int ROWS       = 400;
    localparam int COLS       = 600;
    localparam int CENTER_ROW = 300;
    localparam int CENTER_COL = 200;
    localparam int NPIX       = ROWS * COLS;
    localparam int ADDR_W     = $clog2(NPIX);
    localparam int CNT_W      = $clog2(NPIX + 1);
    localparam int ROW_W      = $clog2(ROWS);
    localparam int COL_W      = $clog2(COLS);

    // field widths
    localparam int RANGE_W = 16;
    localparam int SCALE_W = 8;
    localparam int ANGLE_W = 27;
    localparam int PSNR_W  = 14;
    localparam int DIFF_W  = 18;
    localparam int CFG_W   = 27;

    // register indexes
    localparam logic [1:0] REG_SCALE       = 2'd0;
    localparam logic [1:0] REG_ANGLE_START = 2'd1;
    localparam logic [1:0] REG_ANGLE_STEP  = 2'd2;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 8'd40;

    // angle arithmetic, Q24 radians
    localparam logic [32:0] TWO_PI_Q24  = 33'd105414357;
    localparam logic [27:0] HALF_PI_Q24 = 28'd26353589;
    localparam logic [27:0] QTR_PI_Q24  = 28'(26353589 / 2);
    // 21 turns minus 2^31: lifts any signed 32-bit angle to a positive value
    localparam logic [32:0] MOD_BIAS    = 33'(64'd21 * 64'd105414357 - 64'd2147483648);
    localparam int          MOD_STEPS   = 6;

    localparam logic [30:0] Q30_ONE   = 31'h4000_0000;
    localparam int          SIN_TERMS = 4;
    localparam int          COS_TERMS = 5;

    localparam logic [31:0] RCP_72 = 32'(64'h1_0000_0000 / 72);
    localparam logic [31:0] RCP_42 = 32'(64'h1_0000_0000 / 42);
    localparam logic [31:0] RCP_20 = 32'(64'h1_0000_0000 / 20);
    localparam logic [31:0] RCP_6  = 32'(64'h1_0000_0000 / 6);
    localparam logic [31:0] RCP_90 = 32'(64'h1_0000_0000 / 90);
    localparam logic [31:0] RCP_56 = 32'(64'h1_0000_0000 / 56);
    localparam logic [31:0] RCP_30 = 32'(64'h1_0000_0000 / 30);
    localparam logic [31:0] RCP_12 = 32'(64'h1_0000_0000 / 12);
    localparam logic [31:0] RCP_2  = 32'(64'h1_0000_0000 / 2);

    // 10*log10(2) in Q32 = 3*2^32 + C_LO
    localparam logic [25:0] C_LO     = 26'd44237977;
    localparam logic [13:0] PSNR_MAX = 14'd16383;

    typedef enum logic [3:0] {
        PT_IDLE, PT_MOD, PT_RED, PT_SQ, PT_DIVM, PT_DIVC, PT_MULR, PT_SINF,
        PT_PROJC, PT_PROJS, PT_PIX
    } pt_state_t;

    typedef enum logic [2:0] {
        PS_IDLE, PS_NORM, PS_SQ, PS_SUB, PS_MUL, PS_ADD
    } ps_state_t;

    typedef enum logic [2:0] {
        ST_CLEAR, ST_IDLE, ST_PT, ST_RMW, ST_PSTART, ST_PWAIT, ST_OUT, ST_COPY
    } top_state_t;

    typedef struct packed {
        logic               start;
        logic [RANGE_W-1:0] range;
        logic [SCALE_W-1:0] scale;
        logic [31:0]        theta;
    } pt_cmd_t;

    typedef struct packed {
        logic              done;
        logic              hit;
        logic [ADDR_W-1:0] idx;
    } pt_status_t;

    typedef struct packed {
        logic              start;
        logic [DIFF_W-1:0] diff;
    } ps_cmd_t;

    typedef struct packed {
        logic              done;
        logic [PSNR_W-1:0] psnr;
    } ps_status_t;

    // Taylor divisors: chain 0 is sine, chain 1 cosine
    function automatic logic [6:0] term_div(input logic chain, input logic [2:0] term);
        logic [6:0] d;
        case ({chain, term})
            4'b0_000: d = 7'd72;
            4'b0_001: d = 7'd42;
            4'b0_010: d = 7'd20;
            4'b0_011: d = 7'd6;
            4'b1_000: d = 7'd90;
            4'b1_001: d = 7'd56;
            4'b1_010: d = 7'd30;
            4'b1_011: d = 7'd12;
            4'b1_100: d = 7'd2;
            default:  d = 7'd2;
        endcase
        return d;
    endfunction

    function automatic logic [31:0] term_rcp(input logic chain, input logic [2:0] term);
        logic [31:0] r;
        case ({chain, term})
            4'b0_000: r = RCP_72;
            4'b0_001: r = RCP_42;
            4'b0_010: r = RCP_20;
            4'b0_011: r = RCP_6;
            4'b1_000: r = RCP_90;
            4'b1_001: r = RCP_56;
            4'b1_010: r = RCP_30;
            4'b1_011: r = RCP_12;
            4'b1_100: r = RCP_2;
            default:  r = RCP_2;
        endcase
        return r;
    endfunction

    // log2 in Q24 of a constant, evaluated at elaboration
    function automatic logic [28:0] log2_q24_const(input logic [31:0] v);
        int          k;
        logic [63:0] m;
        logic [28:0] res;
        k = 0;
        for (int i = 0; i < 31; i++) begin
            if (v[i]) begin
                k = i;
            end
        end
        m   = 64'(v) << (30 - k);
        res = 29'(k) << 24;
        for (int i = 23; i >= 0; i--) begin
            m = (m * m) >> 30;
            if (m >= 64'h8000_0000) begin
                m      = m >> 1;
                res[i] = 1'b1;
            end
        end
        return res;
    endfunction

    localparam logic [28:0] LOG2_NPIX = log2_q24_const(32'(NPIX));

endpackage

`default_nettype wire

// ===== rtl/core/srfp_ram.sv =====
// ----------------------------------------------------------------------------
// srfp_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module srfp_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/srfp_point.sv =====
// ----------------------------------------------------------------------------
// srfp_point
// Projects one range sample to a pixel index: angle reduction, Taylor
// sine/cosine on a shared multiplier, projection and bounds check.
// ----------------------------------------------------------------------------
`default_nettype none

module srfp_point (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire srfp_pkg::pt_cmd_t   cmd,
    output srfp_pkg::pt_status_t     status
);

    srfp_pkg::pt_state_t state_reg, state_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic        chain_reg, chain_next;
    logic        done_reg, done_next;

    logic [32:0] sum_reg, sum_next;
    logic [29:0] rq_reg, rq_next;
    logic        neg_reg, neg_next;
    logic [1:0]  quad_reg, quad_next;
    logic [29:0] r2_reg, r2_next;
    logic [30:0] x_reg, x_next;
    logic [31:0] q0_reg, q0_next;
    logic [30:0] acc_reg, acc_next;
    logic [30:0] srm_reg, srm_next;
    logic [23:0] prod_reg, prod_next;
    logic [15:0] pc_reg, pc_next;
    logic [15:0] ps_reg, ps_next;
    logic        hit_reg, hit_next;
    logic [srfp_pkg::ADDR_W-1:0] idx_reg, idx_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;

    logic [26:0] t_red;
    logic [27:0] tt_red;
    logic [27:0] khp;
    logic [2:0]  k_red;
    logic signed [27:0] r_red;
    logic [27:0] mag_red;

    logic [6:0]  div_d;
    logic [38:0] qd;
    logic [31:0] rem;
    logic [31:0] q_fix;
    logic [2:0]  last_term;

    logic [30:0] smag, cmag;
    logic        sneg, cneg;

    logic signed [17:0] row_s, col_s;
    logic [srfp_pkg::ADDR_W-1:0] row_a, col_a;
    logic        in_bounds;

    assign mul_p = mul_a * mul_b;

    // quadrant mapping of the reduced sine/cosine
    always_comb
    begin
        case (quad_reg)
            2'd0:
            begin
                smag = srm_reg; sneg = neg_reg;  cmag = acc_reg; cneg = 1'b0;
            end
            2'd1:
            begin
                smag = acc_reg; sneg = 1'b0;     cmag = srm_reg; cneg = !neg_reg;
            end
            2'd2:
            begin
                smag = srm_reg; sneg = !neg_reg; cmag = acc_reg; cneg = 1'b1;
            end
            default:
            begin
                smag = acc_reg; sneg = 1'b1;     cmag = srm_reg; cneg = neg_reg;
            end
        endcase
    end

    always_comb
    begin
        case (state_reg)
            srfp_pkg::PT_SQ:
            begin
                mul_a = {2'b0, rq_reg};
                mul_b = {2'b0, rq_reg};
            end
            srfp_pkg::PT_DIVM:
            begin
                mul_a = {1'b0, x_reg};
                mul_b = srfp_pkg::term_rcp(chain_reg, cnt_reg);
            end
            srfp_pkg::PT_MULR:
            begin
                mul_a = {2'b0, r2_reg};
                mul_b = {1'b0, acc_reg};
            end
            srfp_pkg::PT_SINF:
            begin
                mul_a = {2'b0, rq_reg};
                mul_b = {1'b0, acc_reg};
            end
            srfp_pkg::PT_PROJC:
            begin
                mul_a = {8'b0, prod_reg};
                mul_b = {1'b0, cmag};
            end
            srfp_pkg::PT_PROJS:
            begin
                mul_a = {8'b0, prod_reg};
                mul_b = {1'b0, smag};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // angle reduction to an offset from the nearest multiple of pi/2
    always_comb
    begin
        t_red  = sum_reg[26:0];
        tt_red = {1'b0, t_red} + srfp_pkg::QTR_PI_Q24;
        if (tt_red >= 28'(4 * srfp_pkg::HALF_PI_Q24))
        begin
            k_red = 3'd4;
        end
        else if (tt_red >= 28'(3 * srfp_pkg::HALF_PI_Q24))
        begin
            k_red = 3'd3;
        end
        else if (tt_red >= 28'(2 * srfp_pkg::HALF_PI_Q24))
        begin
            k_red = 3'd2;
        end
        else if (tt_red >= srfp_pkg::HALF_PI_Q24)
        begin
            k_red = 3'd1;
        end
        else
        begin
            k_red = 3'd0;
        end
        case (k_red)
            3'd1:    khp = srfp_pkg::HALF_PI_Q24;
            3'd2:    khp = 28'(2 * srfp_pkg::HALF_PI_Q24);
            3'd3:    khp = 28'(3 * srfp_pkg::HALF_PI_Q24);
            3'd4:    khp = 28'(4 * srfp_pkg::HALF_PI_Q24);
            default: khp = '0;
        endcase
        r_red   = $signed({1'b0, t_red}) - $signed(khp);
        mag_red = r_red[27] ? 28'(-r_red) : 28'(r_red);
    end

    // reciprocal division correction
    always_comb
    begin
        div_d     = srfp_pkg::term_div(chain_reg, cnt_reg);
        qd        = q0_reg * div_d;
        rem       = {1'b0, x_reg} - qd[31:0];
        q_fix     = q0_reg + ((rem >= {25'b0, div_d}) ? 32'd1 : 32'd0);
        last_term = chain_reg ? 3'(srfp_pkg::COS_TERMS - 1) : 3'(srfp_pkg::SIN_TERMS - 1);
    end

    always_comb
    begin
        row_s = cneg ? 18'(srfp_pkg::CENTER_ROW) + $signed({2'b0, pc_reg})
                     : 18'(srfp_pkg::CENTER_ROW) - $signed({2'b0, pc_reg});
        col_s = sneg ? 18'(srfp_pkg::CENTER_COL) + $signed({2'b0, ps_reg})
                     : 18'(srfp_pkg::CENTER_COL) - $signed({2'b0, ps_reg});
        in_bounds = (row_s > 18'sd0) && (col_s > 18'sd0)
                 && (row_s < $signed(18'(srfp_pkg::ROWS)))
                 && (col_s < $signed(18'(srfp_pkg::COLS)));
        row_a = srfp_pkg::ADDR_W'(row_s[srfp_pkg::ROW_W-1:0]);
        col_a = srfp_pkg::ADDR_W'(col_s[srfp_pkg::COL_W-1:0]);
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        chain_next = chain_reg;
        done_next  = 1'b0;
        sum_next   = sum_reg;
        rq_next    = rq_reg;
        neg_next   = neg_reg;
        quad_next  = quad_reg;
        r2_next    = r2_reg;
        x_next     = x_reg;
        q0_next    = q0_reg;
        acc_next   = acc_reg;
        srm_next   = srm_reg;
        prod_next  = prod_reg;
        pc_next    = pc_reg;
        ps_next    = ps_reg;
        hit_next   = hit_reg;
        idx_next   = idx_reg;
        case (state_reg)
            srfp_pkg::PT_IDLE:
            begin
                if (cmd.start)
                begin
                    sum_next   = {1'b0, cmd.theta ^ 32'h8000_0000} + srfp_pkg::MOD_BIAS;
                    prod_next  = cmd.scale * cmd.range;
                    cnt_next   = 3'(srfp_pkg::MOD_STEPS - 1);
                    state_next = srfp_pkg::PT_MOD;
                end
            end
            srfp_pkg::PT_MOD:
            begin
                if (sum_reg >= (srfp_pkg::TWO_PI_Q24 << cnt_reg))
                begin
                    sum_next = sum_reg - (srfp_pkg::TWO_PI_Q24 << cnt_reg);
                end
                if (cnt_reg == 3'd0)
                begin
                    state_next = srfp_pkg::PT_RED;
                end
                else
                begin
                    cnt_next = cnt_reg - 3'd1;
                end
            end
            srfp_pkg::PT_RED:
            begin
                rq_next    = {mag_red[23:0], 6'b0};
                neg_next   = r_red[27];
                quad_next  = k_red[1:0];
                state_next = srfp_pkg::PT_SQ;
            end
            srfp_pkg::PT_SQ:
            begin
                r2_next    = mul_p[59:30];
                x_next     = {1'b0, mul_p[59:30]};
                chain_next = 1'b0;
                cnt_next   = 3'd0;
                state_next = srfp_pkg::PT_DIVM;
            end
            srfp_pkg::PT_DIVM:
            begin
                q0_next    = mul_p[63:32];
                state_next = srfp_pkg::PT_DIVC;
            end
            srfp_pkg::PT_DIVC:
            begin
                acc_next = srfp_pkg::Q30_ONE - q_fix[30:0];
                if (cnt_reg != last_term)
                begin
                    state_next = srfp_pkg::PT_MULR;
                end
                else if (!chain_reg)
                begin
                    state_next = srfp_pkg::PT_SINF;
                end
                else
                begin
                    state_next = srfp_pkg::PT_PROJC;
                end
            end
            srfp_pkg::PT_MULR:
            begin
                x_next     = mul_p[60:30];
                cnt_next   = cnt_reg + 3'd1;
                state_next = srfp_pkg::PT_DIVM;
            end
            srfp_pkg::PT_SINF:
            begin
                srm_next   = mul_p[60:30];
                x_next     = {1'b0, r2_reg};
                chain_next = 1'b1;
                cnt_next   = 3'd0;
                state_next = srfp_pkg::PT_DIVM;
            end
            srfp_pkg::PT_PROJC:
            begin
                pc_next    = mul_p[53:38];
                state_next = srfp_pkg::PT_PROJS;
            end
            srfp_pkg::PT_PROJS:
            begin
                ps_next    = mul_p[53:38];
                state_next = srfp_pkg::PT_PIX;
            end
            srfp_pkg::PT_PIX:
            begin
                hit_next   = in_bounds;
                idx_next   = row_a * srfp_pkg::ADDR_W'(srfp_pkg::COLS) + col_a;
                done_next  = 1'b1;
                state_next = srfp_pkg::PT_IDLE;
            end
            default:
            begin
                state_next = srfp_pkg::PT_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srfp_pkg::PT_IDLE;
            cnt_reg   <= '0;
            chain_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            chain_reg <= chain_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg  <= sum_next;
        rq_reg   <= rq_next;
        neg_reg  <= neg_next;
        quad_reg <= quad_next;
        r2_reg   <= r2_next;
        x_reg    <= x_next;
        q0_reg   <= q0_next;
        acc_reg  <= acc_next;
        srm_reg  <= srm_next;
        prod_reg <= prod_next;
        pc_reg   <= pc_next;
        ps_reg   <= ps_next;
        hit_reg  <= hit_next;
        idx_reg  <= idx_next;
    end

    assign status.done = done_reg;
    assign status.hit  = hit_reg;
    assign status.idx  = idx_reg;

endmodule

`default_nettype wire

// ===== rtl/core/srfp_psnr.sv =====
// ----------------------------------------------------------------------------
// srfp_psnr
// Iterative log2 of the difference count and scaling to PSNR in Q6.8 dB.
// ----------------------------------------------------------------------------
`default_nettype none

module srfp_psnr (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire srfp_pkg::ps_cmd_t cmd,
    output srfp_pkg::ps_status_t   status
);

    srfp_pkg::ps_state_t state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic        done_reg, done_next;

    logic [30:0] m_reg, m_next;
    logic [4:0]  k_reg, k_next;
    logic [23:0] frac_reg, frac_next;
    logic [28:0] x_reg, x_next;
    logic [54:0] lo_reg, lo_next;
    logic [30:0] x3_reg, x3_next;
    logic [13:0] psnr_reg, psnr_next;

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    logic [31:0] sq;
    logic [28:0] ld;
    logic [63:0] p_sum;

    assign mul_p = mul_a * mul_b;
    assign sq    = mul_p[61:30];
    assign ld    = {k_reg, frac_reg};
    assign p_sum = 64'(lo_reg) + {1'b0, x3_reg, 32'b0} + (64'd1 << 47);

    always_comb
    begin
        case (state_reg)
            srfp_pkg::PS_SQ:
            begin
                mul_a = {1'b0, m_reg};
                mul_b = {1'b0, m_reg};
            end
            srfp_pkg::PS_MUL:
            begin
                mul_a = {3'b0, x_reg};
                mul_b = {6'b0, srfp_pkg::C_LO};
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        done_next  = 1'b0;
        m_next     = m_reg;
        k_next     = k_reg;
        frac_next  = frac_reg;
        x_next     = x_reg;
        lo_next    = lo_reg;
        x3_next    = x3_reg;
        psnr_next  = psnr_reg;
        case (state_reg)
            srfp_pkg::PS_IDLE:
            begin
                if (cmd.start)
                begin
                    if (cmd.diff == '0)
                    begin
                        psnr_next = '0;
                        done_next = 1'b1;
                    end
                    else
                    begin
                        m_next     = 31'(cmd.diff);
                        k_next     = 5'd30;
                        frac_next  = '0;
                        state_next = srfp_pkg::PS_NORM;
                    end
                end
            end
            srfp_pkg::PS_NORM:
            begin
                // one bit of leading-one search per cycle
                if (m_reg[30])
                begin
                    cnt_next   = 5'd23;
                    state_next = srfp_pkg::PS_SQ;
                end
                else
                begin
                    m_next = {m_reg[29:0], 1'b0};
                    k_next = k_reg - 5'd1;
                end
            end
            srfp_pkg::PS_SQ:
            begin
                if (sq[31])
                begin
                    m_next             = sq[31:1];
                    frac_next[cnt_reg] = 1'b1;
                end
                else
                begin
                    m_next = sq[30:0];
                end
                if (cnt_reg == 5'd0)
                begin
                    state_next = srfp_pkg::PS_SUB;
                end
                else
                begin
                    cnt_next = cnt_reg - 5'd1;
                end
            end
            srfp_pkg::PS_SUB:
            begin
                if (ld >= srfp_pkg::LOG2_NPIX)
                begin
                    psnr_next  = '0;
                    done_next  = 1'b1;
                    state_next = srfp_pkg::PS_IDLE;
                end
                else
                begin
                    x_next     = srfp_pkg::LOG2_NPIX - ld;
                    state_next = srfp_pkg::PS_MUL;
                end
            end
            srfp_pkg::PS_MUL:
            begin
                lo_next    = mul_p[54:0];
                x3_next    = {2'b0, x_reg} + {1'b0, x_reg, 1'b0};
                state_next = srfp_pkg::PS_ADD;
            end
            srfp_pkg::PS_ADD:
            begin
                if (p_sum[63:48] > 16'(srfp_pkg::PSNR_MAX))
                begin
                    psnr_next = srfp_pkg::PSNR_MAX;
                end
                else
                begin
                    psnr_next = p_sum[61:48];
                end
                done_next  = 1'b1;
                state_next = srfp_pkg::PS_IDLE;
            end
            default:
            begin
                state_next = srfp_pkg::PS_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= srfp_pkg::PS_IDLE;
            cnt_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        m_reg    <= m_next;
        k_reg    <= k_next;
        frac_reg <= frac_next;
        x_reg    <= x_next;
        lo_reg   <= lo_next;
        x3_reg   <= x3_next;
        psnr_reg <= psnr_next;
    end

    assign status.done = done_reg;
    assign status.psnr = psnr_reg;

endmodule

`default_nettype wire

// ===== rtl/core/scan_raster_frame_psnr.sv =====
// ----------------------------------------------------------------------------
// scan_raster_frame_psnr
// Rasterizes laser scan points into a bitmap and reports the PSNR between
// successive scan frames.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  in      | in_valid / in_ready  | range_q8_8, point_valid, last_point
//  out     | out_valid / out_ready| psnr_db_q8_8, diff_pixels
//  cfg     | cfg_we               | cfg_index, cfg_data (scale, start, step)
//
//  A point's time is set by the sine/cosine sequence on the shared
//  multiplier in srfp_point plus the frame RAM read-modify-write.
//  The last point adds the log2 run and a copy pass over the frame RAM.
//  After reset a clearing pass over the frame RAM runs before the first
//  beat is taken; cfg writes are taken always.
//  A result waiting on out_ready does not hold off input beats until the
//  next result is ready.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_raster_frame_psnr (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [srfp_pkg::RANGE_W-1:0]  range_q8_8,
    input  wire logic                          point_valid,
    input  wire logic                          last_point,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic      [srfp_pkg::PSNR_W-1:0]   psnr_db_q8_8,
    output logic      [srfp_pkg::DIFF_W-1:0]   diff_pixels,
    input  wire logic                          cfg_we,
    input  wire logic [1:0]                    cfg_index,
    input  wire logic [srfp_pkg::CFG_W-1:0]    cfg_data
);

    srfp_pkg::top_state_t state_reg, state_next;

    logic [srfp_pkg::SCALE_W-1:0] scale_reg;
    logic [srfp_pkg::ANGLE_W-1:0] angle_start_reg;
    logic [srfp_pkg::ANGLE_W-1:0] angle_step_reg;

    logic [31:0]                  accum_reg, accum_next;
    logic [srfp_pkg::CNT_W-1:0]   cur_set_reg, cur_set_next;
    logic [srfp_pkg::DIFF_W-1:0]  diff_reg, diff_next;
    logic                         last_reg, last_next;
    logic [srfp_pkg::CNT_W-1:0]   sweep_reg, sweep_next;
    logic                         rd_pend_reg, rd_pend_next;
    logic [srfp_pkg::ADDR_W-1:0]  cp_addr_reg, cp_addr_next;

    logic                         out_valid_reg, out_valid_next;
    logic [srfp_pkg::PSNR_W-1:0]  out_psnr_reg, out_psnr_next;
    logic [srfp_pkg::DIFF_W-1:0]  out_diff_reg, out_diff_next;

    logic                         ram_we, ram_re;
    logic [srfp_pkg::ADDR_W-1:0]  ram_waddr, ram_raddr;
    logic [1:0]                   ram_wdata, ram_rdata;   // [1] current, [0] previous

    srfp_pkg::pt_cmd_t            pt_cmd;
    srfp_pkg::pt_status_t         pt_st;
    srfp_pkg::ps_cmd_t            ps_cmd;
    srfp_pkg::ps_status_t         ps_st;

    logic                         in_beat;

    assign in_beat = in_valid && in_ready;

    srfp_ram #(
        .WIDTH (2),
        .DEPTH (srfp_pkg::NPIX)
    ) u_frame_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    srfp_point u_point (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (pt_cmd),
        .status (pt_st)
    );

    srfp_psnr u_psnr (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (ps_cmd),
        .status (ps_st)
    );

    always_comb
    begin
        pt_cmd.start = in_beat && point_valid;
        pt_cmd.range = range_q8_8;
        pt_cmd.scale = scale_reg;
        pt_cmd.theta = {{5{angle_start_reg[srfp_pkg::ANGLE_W-1]}}, angle_start_reg}
                     + accum_reg;
        ps_cmd.start = (state_reg == srfp_pkg::ST_PSTART);
        ps_cmd.diff  = diff_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        accum_next     = accum_reg;
        cur_set_next   = cur_set_reg;
        diff_next      = diff_reg;
        last_next      = last_reg;
        sweep_next     = sweep_reg;
        rd_pend_next   = 1'b0;
        cp_addr_next   = cp_addr_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_psnr_next  = out_psnr_reg;
        out_diff_next  = out_diff_reg;
        in_ready       = 1'b0;
        ram_we         = 1'b0;
        ram_waddr      = pt_st.idx;
        ram_wdata      = '0;
        ram_re         = 1'b0;
        ram_raddr      = pt_st.idx;
        case (state_reg)
            srfp_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = sweep_reg[srfp_pkg::ADDR_W-1:0];
                ram_wdata = '0;
                if (sweep_reg == srfp_pkg::CNT_W'(srfp_pkg::NPIX - 1))
                begin
                    state_next = srfp_pkg::ST_IDLE;
                end
                else
                begin
                    sweep_next = sweep_reg + 1'b1;
                end
            end
            srfp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    last_next = last_point;
                    if (point_valid)
                    begin
                        accum_next = accum_reg
                            + {{5{angle_step_reg[srfp_pkg::ANGLE_W-1]}}, angle_step_reg};
                        state_next = srfp_pkg::ST_PT;
                    end
                    else if (last_point)
                    begin
                        state_next = srfp_pkg::ST_PSTART;
                    end
                end
            end
            srfp_pkg::ST_PT:
            begin
                if (pt_st.done)
                begin
                    if (pt_st.hit)
                    begin
                        ram_re     = 1'b1;
                        state_next = srfp_pkg::ST_RMW;
                    end
                    else if (last_reg)
                    begin
                        state_next = srfp_pkg::ST_PSTART;
                    end
                    else
                    begin
                        state_next = srfp_pkg::ST_IDLE;
                    end
                end
            end
            srfp_pkg::ST_RMW:
            begin
                if (!ram_rdata[1])
                begin
                    ram_we       = 1'b1;
                    ram_wdata    = {1'b1, ram_rdata[0]};
                    cur_set_next = cur_set_reg + 1'b1;
                    diff_next    = ram_rdata[0] ? diff_reg - 1'b1 : diff_reg + 1'b1;
                end
                state_next = last_reg ? srfp_pkg::ST_PSTART : srfp_pkg::ST_IDLE;
            end
            srfp_pkg::ST_PSTART:
            begin
                state_next = srfp_pkg::ST_PWAIT;
            end
            srfp_pkg::ST_PWAIT:
            begin
                if (ps_st.done)
                begin
                    state_next = srfp_pkg::ST_OUT;
                end
            end
            srfp_pkg::ST_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_psnr_next  = ps_st.psnr;
                    out_diff_next  = diff_reg;
                    // current frame becomes previous: all its pixels now differ
                    diff_next      = srfp_pkg::DIFF_W'(cur_set_reg);
                    cur_set_next   = '0;
                    accum_next     = '0;
                    sweep_next     = '0;
                    state_next     = srfp_pkg::ST_COPY;
                end
            end
            srfp_pkg::ST_COPY:
            begin
                // read entry n while writing back entry n-1 as {0, current}
                if (rd_pend_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = cp_addr_reg;
                    ram_wdata = {1'b0, ram_rdata[1]};
                end
                if (sweep_reg != srfp_pkg::CNT_W'(srfp_pkg::NPIX))
                begin
                    ram_re       = 1'b1;
                    ram_raddr    = sweep_reg[srfp_pkg::ADDR_W-1:0];
                    cp_addr_next = sweep_reg[srfp_pkg::ADDR_W-1:0];
                    rd_pend_next = 1'b1;
                    sweep_next   = sweep_reg + 1'b1;
                end
                else if (!rd_pend_reg)
                begin
                    state_next = srfp_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = srfp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= srfp_pkg::ST_CLEAR;
            scale_reg       <= srfp_pkg::SCALE_RESET;
            angle_start_reg <= '0;
            angle_step_reg  <= '0;
            accum_reg       <= '0;
            cur_set_reg     <= '0;
            diff_reg        <= '0;
            last_reg        <= 1'b0;
            sweep_reg       <= '0;
            rd_pend_reg     <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            accum_reg     <= accum_next;
            cur_set_reg   <= cur_set_next;
            diff_reg      <= diff_next;
            last_reg      <= last_next;
            sweep_reg     <= sweep_next;
            rd_pend_reg   <= rd_pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    srfp_pkg::REG_SCALE:       scale_reg       <= cfg_data[srfp_pkg::SCALE_W-1:0];
                    srfp_pkg::REG_ANGLE_START: angle_start_reg <= cfg_data;
                    srfp_pkg::REG_ANGLE_STEP:  angle_step_reg  <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cp_addr_reg  <= cp_addr_next;
        out_psnr_reg <= out_psnr_next;
        out_diff_reg <= out_diff_next;
    end

    assign out_valid    = out_valid_reg;
    assign psnr_db_q8_8 = out_psnr_reg;
    assign diff_pixels  = out_diff_reg;

`ifndef ASSERT_OFF
    a_ram_no_same_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (ram_we && ram_re) |-> (ram_waddr != ram_raddr))
        else $error("frame RAM read and write hit the same entry");

    a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == srfp_pkg::ST_OUT))
        else $error("result beat raised outside result state");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == srfp_pkg::ST_IDLE)
        |-> ((32'(diff_reg) <= 32'(srfp_pkg::NPIX))
             && (32'(cur_set_reg) <= 32'(srfp_pkg::NPIX))))
        else $error("pixel counts exceed frame size");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && point_valid) |=> !in_ready)
        else $error("input accepted while a point is in flight");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_scan_raster_frame_psnr.sv =====
// ----------------------------------------------------------------------------
// tb_scan_raster_frame_psnr
// Self-checking bench for the scan raster frame PSNR block. Scan beats are
// pushed through the input channel with random gaps. A scoreboard rasterizes
// each beat into its own pair of frame maps, predicts the per-frame PSNR and
// difference count, and checks every output beat against it in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_scan_raster_frame_psnr;

    localparam logic [1:0] REG_SPARE   = 2'd3;  // unmapped index, must be ignored
    localparam longint     TURN_Q24    = 105414357;
    localparam longint     QUARTER_Q24 = 26353589;
    localparam longint     DB_PER_OCT  = 64'd12929139865;  // 10*log10(2), Q32
    localparam int         LIMIT       = 1_500_000_000;
    localparam int         ANGLE_MAX   = 52707179;

    typedef struct {
        logic [srfp_pkg::PSNR_W-1:0] psnr;
        logic [srfp_pkg::DIFF_W-1:0] diff;
    } frame_result_t;

    typedef struct {
        logic [srfp_pkg::RANGE_W-1:0] range;
        logic                         pv;
    } scan_point_t;

    class frame_scoreboard;
        bit              cur_map[srfp_pkg::NPIX];
        bit              prev_map[srfp_pkg::NPIX];
        int unsigned     diff_cnt;
        int unsigned     cur_set;
        logic [31:0]     angle_acc;
        logic [7:0]      scale;
        logic [26:0]     a_start;
        logic [26:0]     a_step;
        frame_result_t   results_q[$];
        int              errors;
        int              frames_done;

        function new();
            scale = srfp_pkg::SCALE_RESET;
            a_start = '0;
            a_step = '0;
            angle_acc = '0;
            diff_cnt = 0;
            cur_set = 0;
            errors = 0;
            frames_done = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic [srfp_pkg::CFG_W-1:0] data);
            case (idx)
                srfp_pkg::REG_SCALE:       scale = data[7:0];
                srfp_pkg::REG_ANGLE_START: a_start = data[26:0];
                srfp_pkg::REG_ANGLE_STEP:  a_step = data[26:0];
                default: ;
            endcase
        endfunction

        // returns sin and cos of theta (Q24) in signed Q30
        function void sin_cos(longint theta, output longint s, output longint c);
            longint t, k, r, sr, cr;
            longint unsigned mag, rq, r2, a, b;
            bit neg;
            t = theta % TURN_Q24;
            if (t < 0)
                t += TURN_Q24;
            k = (t + QUARTER_Q24 / 2) / QUARTER_Q24;
            r = t - k * QUARTER_Q24;
            k = k & 3;
            neg = r < 0;
            mag = neg ? -r : r;
            rq = mag << 6;
            r2 = (rq * rq) >> 30;
            a = (64'd1 << 30) - r2 / 72;
            a = (64'd1 << 30) - ((r2 * a) >> 30) / 42;
            a = (64'd1 << 30) - ((r2 * a) >> 30) / 20;
            a = (64'd1 << 30) - ((r2 * a) >> 30) / 6;
            sr = longint'((rq * a) >> 30);
            if (neg)
                sr = -sr;
            b = (64'd1 << 30) - r2 / 90;
            b = (64'd1 << 30) - ((r2 * b) >> 30) / 56;
            b = (64'd1 << 30) - ((r2 * b) >> 30) / 30;
            b = (64'd1 << 30) - ((r2 * b) >> 30) / 12;
            b = (64'd1 << 30) - ((r2 * b) >> 30) / 2;
            cr = longint'(b);
            case (k)
                0:
                begin
                    s = sr;
                    c = cr;
                end
                1:
                begin
                    s = cr;
                    c = -sr;
                end
                2:
                begin
                    s = -sr;
                    c = -cr;
                end
                default:
                begin
                    s = -cr;
                    c = sr;
                end
            endcase
        endfunction

        function longint scaled_offset(longint unsigned prod, longint trig);
            longint unsigned m;
            longint p;
            m = trig < 0 ? -trig : trig;
            p = longint'((prod * m) >> 38);
            return trig < 0 ? -p : p;
        endfunction

        function void rasterize(logic [srfp_pkg::RANGE_W-1:0] range);
            logic [31:0] theta32;
            longint s, c, row, col;
            longint unsigned prod;
            int idx;
            theta32 = {{5{a_start[26]}}, a_start} + angle_acc;
            sin_cos(longint'(signed'(theta32)), s, c);
            prod = longint'(scale) * longint'(range);
            row = srfp_pkg::CENTER_ROW - scaled_offset(prod, c);
            col = srfp_pkg::CENTER_COL - scaled_offset(prod, s);
            if (row > 0 && col > 0 && row < srfp_pkg::ROWS && col < srfp_pkg::COLS)
            begin
                idx = int'(row) * srfp_pkg::COLS + int'(col);
                if (!cur_map[idx])
                begin
                    cur_map[idx] = 1'b1;
                    cur_set++;
                    if (prev_map[idx])
                        diff_cnt--;
                    else
                        diff_cnt++;
                end
            end
        endfunction

        // log2 in Q24, fraction by repeated squaring
        function longint unsigned log2_fix(int unsigned v);
            int k;
            longint unsigned m, res;
            k = 31;
            while (k > 0 && v[k] == 1'b0)
                k--;
            m = (k <= 30) ? (longint'(v) << (30 - k)) : (longint'(v) >> (k - 30));
            res = longint'(k) << 24;
            for (int i = 23; i >= 0; i--)
            begin
                m = (m * m) >> 30;
                if (m >= (64'd2 << 30))
                begin
                    m = m >> 1;
                    res[i] = 1'b1;
                end
            end
            return res;
        endfunction

        function logic [srfp_pkg::PSNR_W-1:0] psnr_of(int unsigned diff);
            longint unsigned ln, ld, p;
            if (diff == 0)
                return '0;
            ln = log2_fix(srfp_pkg::NPIX);
            ld = log2_fix(diff);
            if (ld >= ln)
                return '0;
            p = ((ln - ld) * DB_PER_OCT + (64'd1 << 47)) >> 48;
            return (p > 16383) ? 14'd16383 : p[13:0];
        endfunction

        function void note_beat(logic [srfp_pkg::RANGE_W-1:0] range, logic pv, logic last);
            frame_result_t r;
            if (pv)
            begin
                rasterize(range);
                angle_acc += {{5{a_step[26]}}, a_step};
            end
            if (last)
            begin
                r.psnr = psnr_of(diff_cnt);
                r.diff = diff_cnt[srfp_pkg::DIFF_W-1:0];
                results_q.push_back(r);
                for (int i = 0; i < srfp_pkg::NPIX; i++)
                begin
                    prev_map[i] = cur_map[i];
                    cur_map[i] = 1'b0;
                end
                diff_cnt = cur_set;
                cur_set = 0;
                angle_acc = '0;
            end
        endfunction

        task report(string what);
            $display("[%0t] mismatch: %s", $time, what);
            errors++;
        endtask

        task check_result(logic [srfp_pkg::PSNR_W-1:0] psnr,
                          logic [srfp_pkg::DIFF_W-1:0] diff);
            frame_result_t e;
            if (results_q.size() == 0)
            begin
                report($sformatf("unexpected frame beat psnr=%0d diff=%0d", psnr, diff));
            end
            else
            begin
                e = results_q.pop_front();
                frames_done++;
                if (psnr !== e.psnr)
                    report($sformatf("frame %0d psnr got %0d want %0d",
                                     frames_done, psnr, e.psnr));
                if (diff !== e.diff)
                    report($sformatf("frame %0d diff got %0d want %0d",
                                     frames_done, diff, e.diff));
            end
        endtask

        function int pending();
            return results_q.size();
        endfunction
    endclass

    logic                           clk;
    logic                           rst_n;
    logic                           in_valid;
    logic                           in_ready;
    logic [srfp_pkg::RANGE_W-1:0]   range_q8_8;
    logic                           point_valid;
    logic                           last_point;
    logic                           out_valid;
    logic                           out_ready;
    logic [srfp_pkg::PSNR_W-1:0]    psnr_db_q8_8;
    logic [srfp_pkg::DIFF_W-1:0]    diff_pixels;
    logic                           cfg_we;
    logic [1:0]                     cfg_index;
    logic [srfp_pkg::CFG_W-1:0]     cfg_data;

    frame_scoreboard      sb;
    int                   cycles;
    int                   beats_sent;
    bit                   calm;
    scan_point_t          prev_scan[$];

    scan_raster_frame_psnr dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .range_q8_8   (range_q8_8),
        .point_valid  (point_valid),
        .last_point   (last_point),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .psnr_db_q8_8 (psnr_db_q8_8),
        .diff_pixels  (diff_pixels),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #10 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(psnr_db_q8_8, diff_pixels);
    end

    // receiver stalls in bursts
    initial
    begin
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 7) == 0)
            begin
                out_ready = 1'b0;
                repeat ($urandom_range(1, 15)) @(negedge clk);
            end
            out_ready = 1'b1;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [srfp_pkg::CFG_W-1:0] data);
        @(negedge clk);
        cfg_we = 1'b1;
        cfg_index = idx;
        cfg_data = data;
        sb.write_reg(idx, data);
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    // called at a falling edge; returns at the falling edge after the beat
    task automatic send_beat(logic [srfp_pkg::RANGE_W-1:0] range, logic pv, logic last);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid = 1'b0;
            repeat ($urandom_range(1, 15)) @(negedge clk);
        end
        in_valid = 1'b1;
        range_q8_8 = range;
        point_valid = pv;
        last_point = last;
        forever
        begin
            @(posedge clk);
            if (in_ready)
                break;
        end
        sb.note_beat(range, pv, last);
        beats_sent++;
        @(negedge clk);
        in_valid = 1'b0;
    endtask

    task automatic drain();
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (100) @(negedge clk);
    endtask

    task automatic send_scan(scan_point_t pts[$]);
        for (int i = 0; i < pts.size(); i++)
            send_beat(pts[i].range, pts[i].pv, i == pts.size() - 1);
    endtask

    function automatic logic [srfp_pkg::RANGE_W-1:0] rand_range();
        if ($urandom_range(0, 4) == 0)
            return srfp_pkg::RANGE_W'($urandom);
        return srfp_pkg::RANGE_W'($urandom_range(0, 2500));
    endfunction

    function automatic logic [srfp_pkg::CFG_W-1:0] rand_angle(int span);
        int v;
        if ($urandom_range(0, 9) == 0)
            return srfp_pkg::CFG_W'($urandom);
        v = int'($urandom_range(0, 2 * span)) - span;
        return srfp_pkg::CFG_W'(v);
    endfunction

    task automatic random_scan();
        scan_point_t pts[$];
        scan_point_t p;
        int n;
        // well-formed rescans of the previous frame with a few points moved
        if (prev_scan.size() != 0 && $urandom_range(0, 1) == 0)
        begin
            pts = prev_scan;
            repeat ($urandom_range(0, 3))
            begin
                n = $urandom_range(0, pts.size() - 1);
                pts[n].range = rand_range();
            end
        end
        else
        begin
            n = $urandom_range(1, 100);
            for (int i = 0; i < n; i++)
            begin
                p.range = rand_range();
                p.pv = ($urandom_range(0, 9) != 0);
                pts.push_back(p);
            end
        end
        send_scan(pts);
        prev_scan = pts;
    endtask

    initial
    begin
        scan_point_t pts[$];
        scan_point_t p;
        sb = new();
        cycles = 0;
        beats_sent = 0;
        calm = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        range_q8_8 = '0;
        point_valid = 1'b0;
        last_point = 1'b0;
        cfg_we = 1'b0;
        cfg_index = srfp_pkg::REG_SCALE;
        cfg_data = '0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // center pixel, far out, one meter, empty beat, two meters, then the same scan again
        p = '{16'h0000, 1'b1}; pts.push_back(p);
        p = '{16'hFFFF, 1'b1}; pts.push_back(p);
        p = '{16'h0100, 1'b1}; pts.push_back(p);
        p = '{16'h5A5A, 1'b0}; pts.push_back(p);
        p = '{16'h0200, 1'b1}; pts.push_back(p);
        send_scan(pts);
        send_scan(pts);
        // empty frames: everything gone, then nothing changes
        send_beat(16'hFFFF, 1'b0, 1'b1);
        send_beat(16'h0000, 1'b0, 1'b1);
        drain();

        write_reg(srfp_pkg::REG_SCALE, 27'd255);
        write_reg(srfp_pkg::REG_ANGLE_START, srfp_pkg::CFG_W'(ANGLE_MAX));
        write_reg(srfp_pkg::REG_ANGLE_STEP, srfp_pkg::CFG_W'(-ANGLE_MAX));
        write_reg(REG_SPARE, 27'h7FF_FFFF);
        send_scan(pts);
        drain();
        write_reg(srfp_pkg::REG_SCALE, 27'd1);
        write_reg(srfp_pkg::REG_ANGLE_START, srfp_pkg::CFG_W'(-ANGLE_MAX));
        write_reg(srfp_pkg::REG_ANGLE_STEP, srfp_pkg::CFG_W'(ANGLE_MAX));
        send_scan(pts);
        drain();
        write_reg(srfp_pkg::REG_SCALE, 27'h7FF_FF00);   // low byte zero: all on center
        send_scan(pts);
        drain();

        while (beats_sent < 1300 || sb.frames_done < 30)
        begin
            if (beats_sent > 1150)
                calm = 1'b1;
            write_reg(srfp_pkg::REG_SCALE, $urandom_range(0, 3) == 0 ?
                      srfp_pkg::CFG_W'($urandom) : srfp_pkg::CFG_W'($urandom_range(10, 80)));
            write_reg(srfp_pkg::REG_ANGLE_START, rand_angle(ANGLE_MAX));
            write_reg(srfp_pkg::REG_ANGLE_STEP,
                      rand_angle($urandom_range(0, 1) ? 2000000 : ANGLE_MAX));
            prev_scan.delete();
            repeat ($urandom_range(1, 3))
                random_scan();
            drain();
        end

        in_valid = 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (400) @(posedge clk);
        if (sb.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/core/srfp_pkg.sv
rtl/core/srfp_ram.sv
rtl/core/srfp_point.sv
rtl/core/srfp_psnr.sv
rtl/core/scan_raster_frame_psnr.sv
tb/tb_scan_raster_frame_psnr.sv
